// ===== design/gapless_block_segmenter_defines.svh =====
// Assertion macros shared by the gapless block segmenter checker.
`ifndef GAPLESS_BLOCK_SEGMENTER_DEFINES_SVH
`define GAPLESS_BLOCK_SEGMENTER_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define GBS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gapless block segmenter: sequence check failed");

// Condition must hold at every clock edge.
`define GBS_ASSERT_NOW(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("gapless block segmenter: invariant check failed");

`endif

// ===== design/gbs_pkg.sv =====
// Package: payload structs, controller/datapath link structs and constants.
`timescale 1ns / 1ps

package gbs_pkg;

    localparam int ROWS_DEFAULT        = 16;
    localparam int MAX_COLUMNS_DEFAULT = 65536;
    localparam int MASK_W              = 16;
    localparam int CFG_W               = 7;
    localparam logic [CFG_W-1:0] MIN_ROWS_RESET = 7'd2;

    typedef struct packed {
        logic [15:0] present_mask;
        logic        last_column;
    } gbs_in_t;

    typedef struct packed {
        logic [15:0] block_start;
        logic [16:0] block_length;
        logic [3:0]  row_number;
        logic [15:0] row_offset;
        logic        last_of_block;
    } gbs_out_t;

    // controller -> datapath
    typedef struct packed {
        logic latch_in;     // capture the accepted column
        logic start_close;  // load row scan from open block
        logic emit_step;    // send one row result
        logic advance;      // bump offsets of present rows, drop block
        logic clear_all;    // end of alignment
        logic join_col;     // column joins or opens a block
    } gbs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic close_needed;
        logic scan_empty;
        logic out_free;
        logic last_col;
    } gbs_stat_t;

endpackage

// ===== design/gbs_ctrl.sv =====
// Controller state machine sequencing one column at a time.
`timescale 1ns / 1ps

module gbs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  gbs_pkg::gbs_stat_t stat,
    output gbs_pkg::gbs_cmd_t  cmd
);
    import gbs_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_EVAL    = 3'd1;
    localparam logic [2:0] ST_EMIT    = 3'd2;
    localparam logic [2:0] ST_ADVANCE = 3'd3;
    localparam logic [2:0] ST_JOIN    = 3'd4;
    localparam logic [2:0] ST_FINAL   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       phase_reg, phase_next;   // 0: mask-change close, 1: final close

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (stat.close_needed)
                begin
                    cmd.start_close = 1'b1;
                    phase_next      = 1'b0;
                    state_next      = ST_EMIT;
                end
                else
                begin
                    state_next = ST_JOIN;
                end
            end
            ST_EMIT:
            begin
                if (stat.scan_empty)
                    state_next = ST_ADVANCE;
                else if (stat.out_free)
                    cmd.emit_step = 1'b1;
            end
            ST_ADVANCE:
            begin
                if (phase_reg)
                begin
                    cmd.clear_all = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_JOIN;
                end
            end
            ST_JOIN:
            begin
                cmd.join_col = 1'b1;
                state_next   = stat.last_col ? ST_FINAL : ST_IDLE;
            end
            ST_FINAL:
            begin
                cmd.start_close = 1'b1;
                phase_next      = 1'b1;
                state_next      = ST_EMIT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

// ===== design/gbs_datapath.sv =====
// Datapath: open block, column counter, row offsets, row scan, output register.
`timescale 1ns / 1ps

module gbs_datapath #(
    parameter int ROWS        = gbs_pkg::ROWS_DEFAULT,
    parameter int MAX_COLUMNS = gbs_pkg::MAX_COLUMNS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  gbs_pkg::gbs_cmd_t         cmd,
    output gbs_pkg::gbs_stat_t        stat,
    input  gbs_pkg::gbs_in_t          in_data,
    input  logic                      cfg_write,
    input  logic [gbs_pkg::CFG_W-1:0] cfg_data,
    input  logic                      out_stall,
    output logic                      out_valid,
    output gbs_pkg::gbs_out_t         out_data
);
    import gbs_pkg::*;

    localparam int ROW_LIMIT = (ROWS < MASK_W) ? ROWS : MASK_W;
    localparam int ROW_W     = $clog2(ROW_LIMIT);
    localparam int CNT_W     = $clog2(ROW_LIMIT + 1);
    localparam int LEN_W     = $clog2(MAX_COLUMNS + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_COLUMNS);

    logic [CFG_W-1:0]     min_rows_reg, min_rows_next;
    logic [ROW_LIMIT-1:0] cur_mask_reg, cur_mask_next;
    logic                 last_reg, last_next;
    logic [ROW_LIMIT-1:0] open_mask_reg, open_mask_next;
    logic [15:0]          open_start_reg, open_start_next;
    logic [LEN_W-1:0]     open_len_reg, open_len_next;
    logic [15:0]          counter_reg, counter_next;
    logic [15:0]          offsets_reg [ROW_LIMIT];
    logic [15:0]          offsets_next [ROW_LIMIT];
    logic [ROW_LIMIT-1:0] scan_reg, scan_next, scan_rest;
    logic                 out_valid_reg, out_valid_next;
    gbs_out_t             out_data_reg, out_data_next;

    logic [CNT_W-1:0]     row_count;
    logic [ROW_W-1:0]     sel_idx;

    // present rows of the open block
    always_comb
    begin
        row_count = '0;
        for (int r = 0; r < ROW_LIMIT; r++)
            row_count = row_count + CNT_W'(open_mask_reg[r]);
    end

    // lowest row still to be sent
    always_comb
    begin
        sel_idx = '0;
        for (int r = ROW_LIMIT - 1; r >= 0; r--)
            if (scan_reg[r])
                sel_idx = ROW_W'(r);
    end

    assign scan_rest = scan_reg & (scan_reg - ROW_LIMIT'(1));

    always_comb
    begin
        min_rows_next   = min_rows_reg;
        cur_mask_next   = cur_mask_reg;
        last_next       = last_reg;
        open_mask_next  = open_mask_reg;
        open_start_next = open_start_reg;
        open_len_next   = open_len_reg;
        counter_next    = counter_reg;
        offsets_next    = offsets_reg;
        scan_next       = scan_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        if (cfg_write)
            min_rows_next = cfg_data;

        if (cmd.latch_in)
        begin
            cur_mask_next = in_data.present_mask[ROW_LIMIT-1:0];
            last_next     = in_data.last_column;
        end

        if (cmd.start_close)
            scan_next = (CFG_W'(row_count) >= min_rows_reg) ? open_mask_reg : '0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        if (cmd.emit_step)
        begin
            out_data_next.block_start   = open_start_reg;
            out_data_next.block_length  = 17'(open_len_reg);
            out_data_next.row_number    = 4'(sel_idx);
            out_data_next.row_offset    = offsets_reg[sel_idx];
            out_data_next.last_of_block = (scan_rest == '0);
            out_valid_next              = 1'b1;
            scan_next                   = scan_rest;
        end

        if (cmd.advance)
        begin
            for (int r = 0; r < ROW_LIMIT; r++)
                if (open_mask_reg[r])
                    offsets_next[r] = offsets_reg[r] + 16'(open_len_reg);
            open_len_next = '0;
        end

        if (cmd.join_col)
        begin
            if (open_len_reg == '0)
            begin
                open_mask_next  = cur_mask_reg;
                open_start_next = counter_reg;
                open_len_next   = LEN_W'(1);
            end
            else if (open_len_reg < LEN_MAX)
            begin
                open_len_next = open_len_reg + LEN_W'(1);
            end
            counter_next = counter_reg + 16'd1;
        end

        if (cmd.clear_all)
        begin
            for (int r = 0; r < ROW_LIMIT; r++)
                offsets_next[r] = '0;
            counter_next    = '0;
            open_mask_next  = '0;
            open_start_next = '0;
            open_len_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_rows_reg   <= MIN_ROWS_RESET;
            last_reg       <= 1'b0;
            open_mask_reg  <= '0;
            open_start_reg <= '0;
            open_len_reg   <= '0;
            counter_reg    <= '0;
            for (int r = 0; r < ROW_LIMIT; r++)
                offsets_reg[r] <= '0;
            scan_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            min_rows_reg   <= min_rows_next;
            last_reg       <= last_next;
            open_mask_reg  <= open_mask_next;
            open_start_reg <= open_start_next;
            open_len_reg   <= open_len_next;
            counter_reg    <= counter_next;
            offsets_reg    <= offsets_next;
            scan_reg       <= scan_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        cur_mask_reg <= cur_mask_next;
        out_data_reg <= out_data_next;
    end

    assign stat.close_needed = (open_len_reg != '0) && (cur_mask_reg != open_mask_reg);
    assign stat.scan_empty   = (scan_reg == '0);
    assign stat.out_free     = !out_valid_reg || !out_stall;
    assign stat.last_col     = last_reg;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== design/gapless_block_segmenter.sv =====
// Top level of the gapless block segmenter.
`timescale 1ns / 1ps

// Gapless block segmenter. Takes one alignment column per input transfer as a
// mask of rows holding a base; runs of identical masks form gapless blocks.
// When a block closes (mask change, or the column flagged last_column) and it
// holds at least min_rows_in_block rows, one result per present row is sent,
// lowest row first, with last_of_block on the final one. Offsets of present
// rows then advance by the block length; after the last column the offsets,
// column counter and open block clear. Only rows below min(ROWS, 16) count.
// Steps: a column that closes nothing is accepted, compared and joined. Each
// closed block adds the row scan (one row result per cycle while the output
// is not stalled), a step that sees the scan empty and one that updates
// offsets; a last column adds a step to start its close. A stalled output
// holds the scan while rows are pending. One column is in work at a time:
// in_stall is high from the cycle after a transfer until the column is done,
// but the output register lets a finished result wait while the next column
// is accepted. min_rows_in_block is written through cfg_valid/cfg_data
// (cfg_ready is always high); write it only while the block is idle.

module gapless_block_segmenter #(
    parameter int ROWS        = gbs_pkg::ROWS_DEFAULT,
    parameter int MAX_COLUMNS = gbs_pkg::MAX_COLUMNS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // column input
    input  logic                      in_valid,
    output logic                      in_stall,
    input  gbs_pkg::gbs_in_t          in_data,
    // row results
    output logic                      out_valid,
    input  logic                      out_stall,
    output gbs_pkg::gbs_out_t         out_data,
    // min_rows_in_block write
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [gbs_pkg::CFG_W-1:0] cfg_data
);
    import gbs_pkg::*;

    gbs_cmd_t  cmd;
    gbs_stat_t stat;

    // register write always taken
    assign cfg_ready = 1'b1;

    gbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    gbs_datapath #(
        .ROWS        (ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

// ===== design/gbs_checker.sv =====
// Port-level checker for the gapless block segmenter, bound to the top level.
`timescale 1ns / 1ps
`include "gapless_block_segmenter_defines.svh"

module gbs_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input gbs_pkg::gbs_out_t         out_data
);
    import gbs_pkg::*;

    // a stalled result holds
    `GBS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
    // one column at a time
    `GBS_ASSERT_NEXT(a_one_column, in_valid && !in_stall, in_stall)
    // no result can appear the cycle after a column transfer
    `GBS_ASSERT_NEXT(a_no_early_result, in_valid && !in_stall, !$rose(out_valid))
    // every emitted block has length
    `GBS_ASSERT_NOW(a_len_nonzero, !out_valid || (out_data.block_length != '0))

endmodule

bind gapless_block_segmenter gbs_checker u_gbs_checker (.*);

// ===== bench/gbs_row_checker.sv =====
// Row result checker for the gapless block segmenter: tracks segments and checks each row result.
`timescale 1ns / 1ps

module gbs_row_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  gbs_pkg::gbs_in_t          in_data,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  gbs_pkg::gbs_out_t         out_data,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [gbs_pkg::CFG_W-1:0] cfg_data,
    output int                        mismatches,
    output int                        pending,
    output int                        columns_seen,
    output int                        rows_seen
);
    import gbs_pkg::*;

    localparam int PRINT_CAP = 40;
    localparam int NROWS     = (ROWS_DEFAULT < 16) ? ROWS_DEFAULT : 16;

    // segment tracker state
    logic [CFG_W-1:0] min_rows;
    logic [15:0]      seg_mask;
    logic [15:0]      seg_start;
    logic [16:0]      seg_len;      // 0: no segment open
    logic [15:0]      col_idx;
    logic [15:0]      base_ofs [NROWS];

    gbs_out_t expected_rows [$];

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic string field_diffs(input gbs_out_t got, input gbs_out_t want);
        string s;
        s = "";
        if (got.block_start !== want.block_start)
            s = {s, $sformatf(" block_start got %0d want %0d",
                              got.block_start, want.block_start)};
        if (got.block_length !== want.block_length)
            s = {s, $sformatf(" block_length got %0d want %0d",
                              got.block_length, want.block_length)};
        if (got.row_number !== want.row_number)
            s = {s, $sformatf(" row_number got %0d want %0d",
                              got.row_number, want.row_number)};
        if (got.row_offset !== want.row_offset)
            s = {s, $sformatf(" row_offset got %0d want %0d",
                              got.row_offset, want.row_offset)};
        if (got.last_of_block !== want.last_of_block)
            s = {s, $sformatf(" last_of_block got %0b want %0b",
                              got.last_of_block, want.last_of_block)};
        return s;
    endfunction

    // close the open segment: queue its rows if enough, then advance offsets
    task automatic close_segment();
        int       i;
        int       present;
        int       top_row;
        gbs_out_t r;
        present = 0;
        top_row = -1;
        for (i = 0; i < NROWS; i++)
            if (seg_mask[i])
            begin
                present++;
                top_row = i;
            end
        if (present >= int'(min_rows))
        begin
            for (i = 0; i < NROWS; i++)
                if (seg_mask[i])
                begin
                    r.block_start   = seg_start;
                    r.block_length  = seg_len;
                    r.row_number    = i[3:0];
                    r.row_offset    = base_ofs[i];
                    r.last_of_block = (i == top_row);
                    expected_rows.push_back(r);
                end
        end
        for (i = 0; i < NROWS; i++)
            if (seg_mask[i])
                base_ofs[i] = base_ofs[i] + seg_len[15:0];
        seg_len = '0;
    endtask

    task automatic take_column(input gbs_in_t c);
        int          i;
        logic [15:0] mask;
        mask = '0;
        for (i = 0; i < NROWS; i++)
            mask[i] = c.present_mask[i];
        if (seg_len != 0 && mask != seg_mask)
            close_segment();
        if (seg_len == 0)
        begin
            seg_mask  = mask;
            seg_start = col_idx;
            seg_len   = 17'd1;
        end
        else if (int'(seg_len) < MAX_COLUMNS_DEFAULT)
            seg_len = seg_len + 17'd1;
        col_idx = col_idx + 16'd1;
        if (c.last_column)
        begin
            close_segment();
            for (i = 0; i < NROWS; i++)
                base_ofs[i] = '0;
            col_idx   = '0;
            seg_mask  = '0;
            seg_start = '0;
            seg_len   = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        gbs_out_t want;
        string    diffs;
        if (!rst_n)
        begin
            min_rows  = MIN_ROWS_RESET;
            seg_mask  = '0;
            seg_start = '0;
            seg_len   = '0;
            col_idx   = '0;
            for (int i = 0; i < NROWS; i++)
                base_ofs[i] = '0;
            expected_rows.delete();
            pending = 0;
        end
        else
        begin
            // results first: anything arriving now belongs to earlier columns
            if (out_valid && !out_stall)
            begin
                rows_seen++;
                if (expected_rows.size() == 0)
                    report($sformatf("row result %0d with nothing expected (row %0d)",
                                     rows_seen, out_data.row_number));
                else
                begin
                    want  = expected_rows.pop_front();
                    diffs = field_diffs(out_data, want);
                    if (diffs != "")
                        report($sformatf("row result %0d:%s", rows_seen, diffs));
                end
            end
            if (cfg_valid && cfg_ready)
                min_rows = cfg_data;
            if (in_valid && !in_stall)
            begin
                columns_seen++;
                take_column(in_data);
            end
            pending = expected_rows.size();
        end
    end

endmodule

// ===== bench/gapless_block_segmenter_tb.sv =====
// Testbench top for the gapless block segmenter: column stimulus, threshold phases, verdict.
`timescale 1ns / 1ps

module gapless_block_segmenter_tb;

    import gbs_pkg::*;

    // Longest legal stretch without any transfer is a settle wait or a stall
    // burst on top of a close; the limit leaves a wide margin over both.
    localparam int QUIET_LIMIT   = 2000;
    // Block may still be updating offsets after a close that emitted nothing.
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_COLUMNS = 22;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    gbs_in_t          in_data;
    logic             out_valid;
    logic             out_stall;
    gbs_out_t         out_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    int mismatches;
    int pending;
    int columns_seen;
    int rows_seen;
    int cfg_writes;
    int quiet_cycles;
    int sent_columns;
    int in_idle_pct;      // chance of an input gap before a column
    int stall_pct;        // chance per cycle of starting an output stall burst

    gapless_block_segmenter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    gbs_row_checker u_row_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .pending      (pending),
        .columns_seen (columns_seen),
        .rows_seen    (rows_seen)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Output side back-pressure: random stall bursts, each followed by an open
    // stretch before the next can start. stall_pct = 0 keeps the output free.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: any transfer on any channel restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= QUIET_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d rows still due",
                     QUIET_LIMIT, pending);
            $display("FAILED: results differ");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // One column transfer. Data changes at the falling edge only, and stays
    // put while the block stalls. in_valid drops only for a deliberate gap.
    task automatic send_column(input logic [15:0] mask, input logic last);
        @(negedge clk);
        if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid              <= 1'b1;
        in_data.present_mask  <= mask;
        in_data.last_column   <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_columns++;
    endtask

    task automatic send_run(input logic [15:0] mask, input int count, input logic last);
        int k;
        for (k = 0; k < count; k++)
            send_column(mask, last && (k == count - 1));
    endtask

    // Threshold write, only with the block drained and settled.
    task automatic write_min_rows(input logic [CFG_W-1:0] value);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // Next segment mask: a spread of row counts, from empty to full, plus
    // near-repeats of the previous mask (single row entering or leaving).
    function automatic logic [15:0] pick_mask(input logic [15:0] prev);
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h0001 << $urandom_range(0, 15);
            3, 4:    return 16'($urandom & $urandom & $urandom);
            5:       return prev ^ (16'h0001 << $urandom_range(0, 15));
            6:       return ~16'($urandom & $urandom);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // One alignment: a few segments of mostly short runs, last column flagged.
    task automatic send_alignment();
        int          segs;
        int          len;
        int          s;
        logic [15:0] mask;
        segs = $urandom_range(1, 5);
        mask = 16'($urandom);
        for (s = 0; s < segs; s++)
        begin
            mask = pick_mask(mask);
            len  = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 12)
                                               : $urandom_range(1, 3);
            send_run(mask, len, s == segs - 1);
        end
    endtask

    function automatic int pick_idle();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 15;
            default: return 40;
        endcase
    endfunction

    initial
    begin
        logic [CFG_W-1:0] thresholds [8];
        int               p;
        int               phase_start;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        cfg_writes   = 0;
        sent_columns = 0;
        in_idle_pct  = 0;
        stall_pct    = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, reset threshold of two rows.
        in_idle_pct = 15;
        stall_pct   = 15;
        send_run(16'hFFFF, 3, 1'b0);          // full-width segment
        send_run(16'h0000, 2, 1'b0);          // empty segment, no rows
        send_run(16'h8001, 2, 1'b0);          // outer rows only
        send_column(16'h0001, 1'b0);          // one row: under threshold
        send_column(16'h7FFE, 1'b1);          // two closes on the last column
        send_column(16'hA5A5, 1'b1);          // one-column alignment
        send_column(16'hFFFF, 1'b0);
        send_column(16'h7FFF, 1'b1);          // 16 + 15 rows from one column
        send_column(16'h0000, 1'b1);          // empty last column
        send_column(16'h5555, 1'b0);
        send_column(16'hAAAA, 1'b0);
        send_column(16'h5555, 1'b1);          // alternating masks, offsets move
        send_column(16'h0001, 1'b1);          // lone row, nothing sent
        send_run(16'h8000, 2, 1'b0);
        send_column(16'hC000, 1'b1);

        // Random part across threshold settings: zero (every nonempty block), one, the row count
        // and just above it, the field maximum, 64, a random value of 3 to 15 and the reset value.
        thresholds[0] = 7'd1;
        thresholds[1] = 7'd0;
        thresholds[2] = 7'd16;
        thresholds[3] = 7'd17;
        thresholds[4] = 7'd127;
        thresholds[5] = 7'd64;
        thresholds[6] = 7'($urandom_range(3, 15));
        thresholds[7] = MIN_ROWS_RESET;
        for (p = 0; p < 8; p++)
        begin
            write_min_rows(thresholds[p]);
            in_idle_pct = pick_idle();
            stall_pct   = pick_idle();
            phase_start = sent_columns;
            while (sent_columns - phase_start < PHASE_COLUMNS)
            begin
                // mostly whole alignments, some lone columns with a random end flag
                if ($urandom_range(0, 9) == 0)
                    send_column(16'($urandom), 1'($urandom_range(0, 1)));
                else
                    send_alignment();
            end
        end

        // Closing stretch, no idling: back-to-back columns with a one-row
        // threshold, runs that grow, shrink and end on a single row.
        in_idle_pct = 0;
        stall_pct   = 0;
        write_min_rows(7'd1);
        send_run(16'h0003, 4, 1'b0);
        send_run(16'h0001, 2, 1'b0);
        send_run(16'h8001, 3, 1'b0);
        send_column(16'h8000, 1'b1);

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("run covered %0d columns and %0d row results over %0d threshold writes,",
                 columns_seen, rows_seen, cfg_writes);
        $display("including empty and full masks, double closes and stalled outputs");
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
